### rtl/eae_pkg.sv
// Shared constants, codes and the queued request type for the indexed array block.
`timescale 1ns / 1ps
package eae_pkg;

  // Storage geometry
  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths on the stream ports
  localparam int CMD_W       = 3;
  localparam int POS_W       = 6;
  localparam int ELEM_W      = 32;
  localparam int COUNT_OUT_W = 7;
  localparam int STATUS_W    = 2;
  localparam int S_TDATA_W   = 48;
  localparam int M_TDATA_W   = 48;

  // Command codes as they arrive on the input stream
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

  // Internal operation codes after decode
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_POP    = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ   = 3'd5;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd6;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd7;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  // Decoded request held in the queue between front and back
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] element;
  } item_t;

endpackage

### rtl/eae_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module eae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/eae_front.sv
// Front end: takes requests off the input stream, decodes them, and queues them.
`timescale 1ns / 1ps
module eae_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // s_tdata: cmd[2:0], position[8:3], element_in[40:9], zero fill above
  input  logic [eae_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                         q_valid,
  input  logic                         q_ready,
  output eae_pkg::item_t               q_item
);
  import eae_pkg::*;

  logic [CMD_W-1:0]  cmd;
  logic [POS_W-1:0]  position;
  logic [ELEM_W-1:0] element_in;
  item_t             item_in;

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  // Unpack the request
  assign cmd        = s_tdata[CMD_W-1:0];
  assign position   = s_tdata[CMD_W +: POS_W];
  assign element_in = s_tdata[CMD_W+POS_W +: ELEM_W];

  // Decode the command; the unused code becomes a no-op
  always_comb begin
    item_in.position = position;
    item_in.element  = DATA_W'(element_in);
    unique case (cmd)
      CMD_APPEND: item_in.op = OP_APPEND;
      CMD_POP:    item_in.op = OP_POP;
      CMD_INSERT: item_in.op = OP_INSERT;
      CMD_ERASE:  item_in.op = OP_ERASE;
      CMD_READ:   item_in.op = OP_READ;
      CMD_WRITE:  item_in.op = OP_WRITE;
      CMD_CLEAR:  item_in.op = OP_CLEAR;
      default:    item_in.op = OP_NOP;
    endcase
  end

  // Two-entry queue
  assign s_tready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      priority if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

### rtl/eae_back.sv
// Back end: executes queued requests against the element store and registers the result.
`timescale 1ns / 1ps
module eae_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  eae_pkg::item_t                q_item,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: element_out[31:0], count_now[38:32], is_empty[39], status[41:40],
  // zero fill above
  output logic [eae_pkg::M_TDATA_W-1:0] m_tdata
);
  import eae_pkg::*;

  localparam logic [1:0] S_IDLE      = 2'd0;
  localparam logic [1:0] S_READ_WAIT = 2'd1;
  localparam logic [1:0] S_SHIFT_UP  = 2'd2;
  localparam logic [1:0] S_SHIFT_DN  = 2'd3;

  logic [1:0]        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] pos, pos_next;
  logic [DATA_W-1:0] val, val_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [ADDR_W-1:0] tgt, tgt_next;
  logic              pend, pend_next;
  logic              cap, cap_next;
  logic [DATA_W-1:0] res, res_next;

  // Output register
  logic [ELEM_W-1:0]      out_elem;
  logic [COUNT_OUT_W-1:0] out_count;
  logic                   out_empty;
  logic [STATUS_W-1:0]    out_status;

  // Result load
  logic                load;
  logic [DATA_W-1:0]   load_elem;
  logic [STATUS_W-1:0] load_status;

  // Store port
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [DATA_W-1:0] rdata;

  logic             take;
  logic [CNT_W-1:0] pos_ext;
  logic [CNT_W-1:0] ins_pos;
  logic             full;
  logic             in_range;

  eae_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // A new request starts only with the output register free
  assign q_ready  = (state == S_IDLE) && !m_tvalid;
  assign take     = q_valid && q_ready;
  assign pos_ext  = CNT_W'(q_item.position);
  assign ins_pos  = (pos_ext > count) ? count : pos_ext;
  assign full     = (count == CNT_W'(CAPACITY));
  assign in_range = (pos_ext < count);

  // Sequencer
  always_comb begin
    state_next  = state;
    count_next  = count;
    pos_next    = pos;
    val_next    = val;
    idx_next    = idx;
    tgt_next    = tgt;
    pend_next   = pend;
    cap_next    = cap;
    res_next    = res;
    load        = 1'b0;
    load_elem   = '0;
    load_status = STATUS_OK;
    we          = 1'b0;
    waddr       = '0;
    wdata       = val;
    raddr       = '0;

    unique case (state)
      S_IDLE: begin
        if (take) begin
          val_next = q_item.element;
          unique case (q_item.op)
            OP_APPEND: begin
              load = 1'b1;
              if (full) begin
                load_status = STATUS_FULL;
              end else begin
                we         = 1'b1;
                waddr      = count[ADDR_W-1:0];
                wdata      = q_item.element;
                count_next = count + 1'b1;
              end
            end
            OP_POP: begin
              if (count == '0) begin
                load        = 1'b1;
                load_status = STATUS_RANGE;
              end else begin
                raddr      = ADDR_W'(count - 1'b1);
                count_next = count - 1'b1;
                state_next = S_READ_WAIT;
              end
            end
            OP_INSERT: begin
              if (full) begin
                load        = 1'b1;
                load_status = STATUS_FULL;
              end else begin
                pos_next   = ins_pos[ADDR_W-1:0];
                idx_next   = count;
                pend_next  = 1'b0;
                state_next = S_SHIFT_UP;
              end
            end
            OP_ERASE: begin
              if (!in_range) begin
                load        = 1'b1;
                load_status = STATUS_RANGE;
              end else begin
                raddr      = pos_ext[ADDR_W-1:0];
                cap_next   = 1'b1;
                pend_next  = 1'b0;
                idx_next   = pos_ext + 1'b1;
                state_next = S_SHIFT_DN;
              end
            end
            OP_READ: begin
              if (!in_range) begin
                load        = 1'b1;
                load_status = STATUS_RANGE;
              end else begin
                raddr      = pos_ext[ADDR_W-1:0];
                state_next = S_READ_WAIT;
              end
            end
            OP_WRITE: begin
              load = 1'b1;
              if (!in_range) begin
                load_status = STATUS_RANGE;
              end else begin
                we    = 1'b1;
                waddr = pos_ext[ADDR_W-1:0];
                wdata = q_item.element;
              end
            end
            OP_CLEAR: begin
              load       = 1'b1;
              count_next = '0;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end

      S_READ_WAIT: begin
        load       = 1'b1;
        load_elem  = rdata;
        state_next = S_IDLE;
      end

      // Move entries up one slot, top first; each write of slot i overlaps the read of slot i-2
      S_SHIFT_UP: begin
        if (pend) begin
          we    = 1'b1;
          waddr = tgt;
          wdata = rdata;
        end
        priority if (idx > CNT_W'(pos)) begin
          raddr     = ADDR_W'(idx - 1'b1);
          idx_next  = idx - 1'b1;
          tgt_next  = idx[ADDR_W-1:0];
          pend_next = 1'b1;
        end else if (pend) begin
          pend_next = 1'b0;
        end else begin
          we         = 1'b1;
          waddr      = pos;
          wdata      = val;
          count_next = count + 1'b1;
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end

      // Capture the erased entry, then move later entries down one slot
      S_SHIFT_DN: begin
        if (cap) begin
          res_next = rdata;
          cap_next = 1'b0;
        end
        if (pend) begin
          we    = 1'b1;
          waddr = tgt;
          wdata = rdata;
        end
        priority if (idx < count) begin
          raddr     = idx[ADDR_W-1:0];
          tgt_next  = ADDR_W'(idx - 1'b1);
          idx_next  = idx + 1'b1;
          pend_next = 1'b1;
        end else if (pend || cap) begin
          pend_next = 1'b0;
        end else begin
          count_next = count - 1'b1;
          load       = 1'b1;
          load_elem  = res;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      cap   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      cap   <= cap_next;
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    val <= val_next;
    idx <= idx_next;
    tgt <= tgt_next;
    res <= res_next;
  end

  // Result register, held until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_elem   <= ELEM_W'(load_elem);
      out_count  <= COUNT_OUT_W'(count_next);
      out_empty  <= (count_next == '0);
      out_status <= load_status;
    end
  end

  assign m_tdata = {{(M_TDATA_W - ELEM_W - COUNT_OUT_W - 1 - STATUS_W){1'b0}},
                    out_status, out_empty, out_count, out_elem};

endmodule

### rtl/indexed_array_insert_erase_top.sv
// Throughput: one request in the back end at a time; the store's single write port moves one element
// per cycle during insert and erase shifts. Two requests queue ahead while one executes.
// Reset: synchronous, clears the count, the queue and the result register; stored elements
// are left as they are and no clearing pass runs.
`timescale 1ns / 1ps
module indexed_array_insert_erase_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata: cmd[2:0], position[8:3], element_in[40:9], zero fill above
  input  logic [eae_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: element_out[31:0], count_now[38:32], is_empty[39], status[41:40],
  // zero fill above
  output logic [eae_pkg::M_TDATA_W-1:0] m_tdata
);
  import eae_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  eae_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  eae_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule
